@@ hw/rtl/fresnel_dielectric_reflectance_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Fresnel reflectance unit.
// Each macro states a property on the rising edge of the given clock and is
// switched off while the given active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_UNIT_ASSERT_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FDR_ASSERT_IMP(lbl, clk_i, rst_ni, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FDR_ASSERT_NXT(lbl, clk_i, rst_ni, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/fdr_pkg.sv @@
// ----------------------------------------------------------------------------
// fdr_pkg
// Shared constants and types of the Fresnel reflectance unit.
// ----------------------------------------------------------------------------
package fdr_pkg;

	localparam int FRAC_BITS_DEF   = 14;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int INT_FRAC        = 16;
	localparam int QDIV_BITS       = 30;
	localparam int CQ_W            = 17;
	localparam int OUT_W           = 15;

	localparam logic [15:0] ETA_ONE = 16'd4096;

	// One classified word: index numerator and denominator, cosine in Q16.
	typedef struct packed {
		logic [15:0]     en;
		logic [15:0]     ed;
		logic [CQ_W-1:0] cq;
	} work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic valid;
		logic push;
	} fr_ctl_t;

endpackage

@@ hw/rtl/fdr_front.sv @@
// ----------------------------------------------------------------------------
// fdr_front
// Input register: clamps the cosine, picks the index orientation, converts.
// ----------------------------------------------------------------------------
module fdr_front #(
	parameter int FRAC_BITS = fdr_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] cos_incident,
	input  logic        [15:0] eta,
	input  fdr_pkg::q_stat_t   q_stat,
	output fdr_pkg::fr_ctl_t   ctl,
	output fdr_pkg::work_t     word
);

	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
	localparam int SHL = (FRAC_BITS <= fdr_pkg::INT_FRAC) ? fdr_pkg::INT_FRAC - FRAC_BITS : 0;
	localparam int SHR = (FRAC_BITS > fdr_pkg::INT_FRAC) ? FRAC_BITS - fdr_pkg::INT_FRAC : 0;

	logic               valid_q;
	fdr_pkg::work_t     word_s1;
	fdr_pkg::work_t     word_nx;
	logic signed [31:0] c_cl;
	logic        [31:0] c_abs;
	logic        [32:0] c_ext;
	logic        [15:0] e_nz;
	logic               take;

	assign full     = valid_q & q_stat.full;
	assign take     = push & ~full;
	assign ctl.push = valid_q & ~q_stat.full;
	assign ctl.valid = valid_q;
	assign word     = word_s1;

	always_comb begin
		c_cl = 32'(cos_incident);
		if (c_cl > ONE) begin
			c_cl = ONE;
		end
		if (c_cl < -ONE) begin
			c_cl = -ONE;
		end
		c_abs = (c_cl < 0) ? 32'(-c_cl) : 32'(c_cl);
		c_ext = ({1'b0, c_abs} << SHL) >> SHR;
		e_nz  = (eta == 16'd0) ? 16'd1 : eta;
		word_nx.cq = c_ext[fdr_pkg::CQ_W-1:0];
		if (c_cl < 0) begin
			word_nx.en = fdr_pkg::ETA_ONE;
			word_nx.ed = e_nz;
		end else begin
			word_nx.en = e_nz;
			word_nx.ed = fdr_pkg::ETA_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (ctl.push) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_s1 <= word_nx;
		end
	end

endmodule

@@ hw/rtl/fdr_queue.sv @@
// ----------------------------------------------------------------------------
// fdr_queue
// Short register queue between the front and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module fdr_queue #(
	parameter int DEPTH = fdr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fdr_pkg::work_t   wr_word,
	input  logic             pop,
	output fdr_pkg::work_t   rd_word,
	output fdr_pkg::q_stat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	fdr_pkg::work_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_word    = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= nxt(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= nxt(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_word;
		end
	end

endmodule

@@ hw/rtl/fdr_qdiv.sv @@
// ----------------------------------------------------------------------------
// fdr_qdiv
// Pipelined restoring divider: |p-q| / (p+q) as a truncated Q30 fraction.
// ----------------------------------------------------------------------------
module fdr_qdiv #(
	parameter int P_W = 32
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [P_W-1:0]              p,
	input  logic [P_W-1:0]              q,
	output logic [fdr_pkg::QDIV_BITS:0] quo
);

	localparam int QB = fdr_pkg::QDIV_BITS;
	localparam int DW = P_W + 1;

	logic [DW-1:0] rem_s [QB+1];
	logic [DW-1:0] dv_s  [QB+1];
	logic [QB-1:0] qt_s  [QB+1];

	for (genvar i = 0; i <= QB; i++) begin : g_st
		if (i == 0) begin : g_in
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[0] <= (p >= q) ? DW'(p - q) : DW'(q - p);
					dv_s[0]  <= DW'(p) + DW'(q);
					qt_s[0]  <= '0;
				end
			end
		end else begin : g_it
			logic [DW:0] rs;
			logic        ge;
			logic [DW:0] df;
			assign rs = {rem_s[i-1], 1'b0};
			assign ge = rs >= {1'b0, dv_s[i-1]};
			assign df = rs - {1'b0, dv_s[i-1]};
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= ge ? df[DW-1:0] : rs[DW-1:0];
					dv_s[i]  <= dv_s[i-1];
					qt_s[i]  <= {qt_s[i-1][QB-2:0], ge};
				end
			end
		end
	end

	// A remainder still reaching the divisor means the ratio was exactly one.
	always_ff @(posedge clk) begin
		if (en) begin
			quo <= (rem_s[QB] >= dv_s[QB]) ? (QB+1)'(1) << QB : {1'b0, qt_s[QB]};
		end
	end

endmodule

@@ hw/rtl/fdr_back.sv @@
// ----------------------------------------------------------------------------
// fdr_back
// Arithmetic pipeline: squares, the reflection test, square root, the two
// amplitude ratios and the final averaging with rounding and saturation.
// ----------------------------------------------------------------------------
module fdr_back #(
	parameter int FRAC_BITS = fdr_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fdr_pkg::work_t            wr,
	input  fdr_pkg::q_stat_t          qs,
	output logic                      q_pop,
	input  logic                      pop,
	output logic                      empty,
	output logic [fdr_pkg::OUT_W-1:0] reflectance,
	output logic                      total_internal
);

	localparam int SQ_N = 32;
	localparam int QB   = fdr_pkg::QDIV_BITS;
	localparam int DV_LAT = QB + 2;
	localparam int NST  = 3 + (SQ_N + 1) + 1 + DV_LAT + 2;
	localparam int LAST = NST - 1;
	localparam logic [61:0] ONE = 62'd1 << FRAC_BITS;
	localparam logic [61:0] HALF = 62'd1 << (60 - FRAC_BITS);

	logic [NST-1:0] vld_q;
	logic           adv;

	assign adv   = ~vld_q[LAST] | pop;
	assign q_pop = adv & ~qs.empty;
	assign empty = ~vld_q[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], ~qs.empty};
		end
	end

	// Squares of the index terms and the cosine.
	logic [15:0] ed_s1;
	logic [16:0] cq_s1;
	logic [31:0] en2_s1, ed2_s1;
	logic [32:0] cq2_s1;
	logic [33:0] cq2_w;

	assign cq2_w = 34'(wr.cq) * 34'(wr.cq);

	always_ff @(posedge clk) begin
		if (adv) begin
			ed_s1  <= wr.ed;
			cq_s1  <= wr.cq;
			en2_s1 <= 32'(wr.en) * 32'(wr.en);
			ed2_s1 <= 32'(wr.ed) * 32'(wr.ed);
			cq2_s1 <= cq2_w[32:0];
		end
	end

	// sin^2 of the incident angle and the cosine products used by both ratios.
	logic [15:0] ed_s2;
	logic [31:0] en2_s2, ed2_s2, pc1_s2;
	logic [32:0] s2_s2;
	logic [47:0] pc2_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			ed_s2  <= ed_s1;
			en2_s2 <= en2_s1;
			ed2_s2 <= ed2_s1;
			s2_s2  <= 33'h1_0000_0000 - cq2_s1;
			pc1_s2 <= 32'(ed_s1) * 32'(cq_s1);
			pc2_s2 <= 48'(en2_s1) * 48'(cq_s1);
		end
	end

	logic [15:0] ed_s3;
	logic [31:0] pc1_s3;
	logic [47:0] pc2_s3;
	logic [63:0] lhs_s3, rhs_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			ed_s3  <= ed_s2;
			pc1_s3 <= pc1_s2;
			pc2_s3 <= pc2_s2;
			lhs_s3 <= {en2_s2, 32'd0};
			rhs_s3 <= s2_s2[32] ? {ed2_s2, 32'd0} : 64'(ed2_s2) * 64'(s2_s2[31:0]);
		end
	end

	// Stage 0 of the root line takes the reflection test; the rest resolve
	// one root bit each.
	logic [63:0] sqx_s [SQ_N+1];
	logic [63:0] sqr_s [SQ_N+1];
	logic        sqt_s [SQ_N+1];
	logic [15:0] sqe_s [SQ_N+1];
	logic [31:0] sqa_s [SQ_N+1];
	logic [47:0] sqb_s [SQ_N+1];

	for (genvar k = 0; k <= SQ_N; k++) begin : g_sq
		if (k == 0) begin : g_tir
			always_ff @(posedge clk) begin
				if (adv) begin
					sqx_s[0] <= lhs_s3 - rhs_s3;
					sqr_s[0] <= '0;
					sqt_s[0] <= lhs_s3 <= rhs_s3;
					sqe_s[0] <= ed_s3;
					sqa_s[0] <= pc1_s3;
					sqb_s[0] <= pc2_s3;
				end
			end
		end else begin : g_bit
			localparam logic [63:0] BIT = 64'd1 << (62 - 2 * (k - 1));
			logic [63:0] t;
			assign t = sqr_s[k-1] + BIT;
			always_ff @(posedge clk) begin
				if (adv) begin
					if (sqx_s[k-1] >= t) begin
						sqx_s[k] <= sqx_s[k-1] - t;
						sqr_s[k] <= (sqr_s[k-1] >> 1) + BIT;
					end else begin
						sqx_s[k] <= sqx_s[k-1];
						sqr_s[k] <= sqr_s[k-1] >> 1;
					end
					sqt_s[k] <= sqt_s[k-1];
					sqe_s[k] <= sqe_s[k-1];
					sqa_s[k] <= sqa_s[k-1];
					sqb_s[k] <= sqb_s[k-1];
				end
			end
		end
	end

	// Operands of the parallel and perpendicular ratios.
	logic [31:0] h;
	logic [31:0] p1_s4, q1_s4;
	logic [47:0] p2_s4, q2_s4;
	logic        tir_s4;

	assign h = sqr_s[SQ_N][31:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s4  <= sqa_s[SQ_N];
			q1_s4  <= h;
			p2_s4  <= sqb_s[SQ_N];
			q2_s4  <= 48'(sqe_s[SQ_N]) * 48'(h);
			tir_s4 <= sqt_s[SQ_N];
		end
	end

	logic [QB:0] r1, r2;

	fdr_qdiv #(.P_W(32)) u_div_par (
		.clk (clk),
		.en  (adv),
		.p   (p1_s4),
		.q   (q1_s4),
		.quo (r1)
	);

	fdr_qdiv #(.P_W(48)) u_div_perp (
		.clk (clk),
		.en  (adv),
		.p   (p2_s4),
		.q   (q2_s4),
		.quo (r2)
	);

	logic tird_s [DV_LAT];

	always_ff @(posedge clk) begin
		if (adv) begin
			tird_s[0] <= tir_s4;
			for (int i = 1; i < DV_LAT; i++) begin
				tird_s[i] <= tird_s[i-1];
			end
		end
	end

	logic [61:0] sq1_s5, sq2_s5;
	logic        tir_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq1_s5 <= 62'(r1) * 62'(r1);
			sq2_s5 <= 62'(r2) * 62'(r2);
			tir_s5 <= tird_s[DV_LAT-1];
		end
	end

	logic [61:0] sum, res, sat;
	logic [fdr_pkg::OUT_W-1:0] refl_s6;
	logic                      tir_s6;

	always_comb begin
		sum = sq1_s5 + sq2_s5 + HALF;
		res = sum >> (61 - FRAC_BITS);
		sat = (res > ONE) ? ONE : res;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			refl_s6 <= tir_s5 ? ONE[fdr_pkg::OUT_W-1:0] : sat[fdr_pkg::OUT_W-1:0];
			tir_s6  <= tir_s5;
		end
	end

	assign reflectance    = refl_s6;
	assign total_internal = tir_s6;

endmodule

@@ hw/rtl/fresnel_dielectric_reflectance_unit.sv @@
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance_unit: unpolarized dielectric Fresnel term.
// Path from accept to result: input register, queue, then the 71-stage
// back pipeline, whose first stage loads from the head of the queue.
// Throughput one word per cycle while the last stage is free or popped;
// the 33-stage root line and the 32-stage divider set the depth.
// Asynchronous reset clears valid flags and queue pointers, not the payload.
// ----------------------------------------------------------------------------
`include "fresnel_dielectric_reflectance_unit_assert.svh"

module fresnel_dielectric_reflectance_unit #(
	parameter int FRAC_BITS   = fdr_pkg::FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = fdr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic signed [15:0]        cos_incident,
	input  logic        [15:0]        eta,
	output logic                      empty,
	input  logic                      pop,
	output logic [fdr_pkg::OUT_W-1:0] reflectance,
	output logic                      total_internal
);

	localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

	// The front register holds one classified word until the queue has room.
	// The back pipeline advances as a whole whenever its last stage is free
	// or being popped, drawing a new word from the queue, if it holds one, each such cycle.
	fdr_pkg::work_t   fr_word;
	fdr_pkg::work_t   bk_word;
	fdr_pkg::fr_ctl_t fr_ctl;
	fdr_pkg::q_stat_t q_stat;
	logic             q_pop;

	fdr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.cos_incident (cos_incident),
		.eta          (eta),
		.q_stat       (q_stat),
		.ctl          (fr_ctl),
		.word         (fr_word)
	);

	fdr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fr_ctl.push),
		.wr_word (fr_word),
		.pop     (q_pop),
		.rd_word (bk_word),
		.stat    (q_stat)
	);

	fdr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr             (bk_word),
		.qs             (q_stat),
		.q_pop          (q_pop),
		.pop            (pop),
		.empty          (empty),
		.reflectance    (reflectance),
		.total_internal (total_internal)
	);

	// A flagged total reflection always carries exactly one.
	`FDR_ASSERT_IMP(a_tir_one, clk, arst_n, !empty && total_internal, reflectance == ONE[fdr_pkg::OUT_W-1:0], "total reflection word is not one")
	// In the standard format the result never exceeds one.
	`FDR_ASSERT_IMP(a_sat, clk, arst_n, !empty && (FRAC_BITS <= 14), reflectance <= ONE[fdr_pkg::OUT_W-1:0], "reflectance above one")
	// The front never pushes into a full queue.
	`FDR_ASSERT_IMP(a_q_ovf, clk, arst_n, fr_ctl.push, !q_stat.full, "push into full queue")
	// An accepted word is held by the front register in the next cycle.
	`FDR_ASSERT_NXT(a_take, clk, arst_n, push && !full, fr_ctl.valid, "accepted word was lost")

endmodule
